FILE: design/jdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the JPEG dequantizer / inverse zigzag unit.
// No dependencies.
package jdq_pkg;

	localparam int NUM_TABLES    = 4;
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = 6;
	localparam int STEP_W        = 8;
	localparam int SAMPLE_W      = 16;
	localparam int QT_DEPTH      = NUM_TABLES * TABLE_ENTRIES;
	localparam int QT_AW         = (QT_DEPTH > 1) ? $clog2(QT_DEPTH) : 1;
	localparam int BUF_DEPTH     = 2 * TABLE_ENTRIES;
	localparam int BUF_AW        = $clog2(BUF_DEPTH);
	localparam int BANK_BIT      = BUF_AW - 1;

	localparam logic             KIND_TABLE = 1'b0;
	localparam logic             KIND_COEF  = 1'b1;
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [IDX_W-1:0] ZZ_TO_RASTER [TABLE_ENTRIES] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	typedef struct packed {
		logic                       kind;
		logic [1:0]                 table_id;
		logic [IDX_W-1:0]           entry_index;
		logic [STEP_W-1:0]          table_value;
		logic signed [SAMPLE_W-1:0] coefficient;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [IDX_W-1:0]           natural_index;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic                en;
		logic                done;
		logic [BUF_AW-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} buf_wr_t;

	typedef struct packed {
		logic              re;
		logic [BUF_AW-1:0] addr;
	} buf_rd_t;

endpackage

FILE: design/jdq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/jdq_fill.sv
`timescale 1ns / 1ps
// Input side: quantizer table store, step lookup, multiply, buffer write.
// Depends on jdq_pkg and jdq_ram.
module jdq_fill (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  jdq_pkg::in_item_t src_data,
	input  logic [1:0]        full,
	output jdq_pkg::buf_wr_t  wr
);

	logic                               acc;
	logic                               tid_ok;
	logic                               q_we;
	logic                               q_re;
	logic [jdq_pkg::QT_AW-1:0]          q_waddr;
	logic [jdq_pkg::QT_AW-1:0]          q_raddr;
	logic [jdq_pkg::STEP_W-1:0]         q_rdata;
	logic [jdq_pkg::STEP_W-1:0]         step;
	logic [23:0]                        prod;
	logic [jdq_pkg::IDX_W-1:0]          coef_cnt_q;
	logic                               fill_bank_q;
	logic                               v_s1;
	logic                               ok_s1;
	logic                               bank_s1;
	logic [jdq_pkg::IDX_W-1:0]          pos_s1;
	logic [jdq_pkg::SAMPLE_W-1:0]       coef_s1;

	assign src_stall = full[fill_bank_q];
	assign acc       = src_valid && !src_stall;
	assign tid_ok    = int'(src_data.table_id) < jdq_pkg::NUM_TABLES;
	assign q_we      = acc && (src_data.kind == jdq_pkg::KIND_TABLE) && tid_ok;
	assign q_re      = acc && (src_data.kind == jdq_pkg::KIND_COEF) && tid_ok;
	assign q_waddr   = jdq_pkg::QT_AW'({src_data.table_id, src_data.entry_index});
	assign q_raddr   = jdq_pkg::QT_AW'({src_data.table_id, coef_cnt_q});

	jdq_ram #(
		.WIDTH (jdq_pkg::STEP_W),
		.DEPTH (jdq_pkg::QT_DEPTH)
	) u_qt_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (src_data.table_value),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_cnt_q  <= '0;
			fill_bank_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= acc && (src_data.kind == jdq_pkg::KIND_COEF);
			if (acc && (src_data.kind == jdq_pkg::KIND_COEF)) begin
				coef_cnt_q <= coef_cnt_q + 1'b1;
				if (coef_cnt_q == jdq_pkg::LAST_IDX) begin
					fill_bank_q <= !fill_bank_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1   <= tid_ok;
			bank_s1 <= fill_bank_q;
			pos_s1  <= coef_cnt_q;
			coef_s1 <= src_data.coefficient;
		end
	end

	// low 16 bits of the signed product match those of the unsigned one
	assign step = ok_s1 ? q_rdata : '0;
	assign prod = {8'd0, coef_s1} * {16'd0, step};

	always_comb begin
		wr.en   = v_s1;
		wr.done = v_s1 && (pos_s1 == jdq_pkg::LAST_IDX);
		wr.addr = {bank_s1, jdq_pkg::ZZ_TO_RASTER[pos_s1]};
		wr.data = prod[jdq_pkg::SAMPLE_W-1:0];
	end

endmodule

FILE: design/jdq_drain.sv
`timescale 1ns / 1ps
// Output side: bank full flags, raster-order buffer reads, output register.
// Depends on jdq_pkg.
module jdq_drain (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jdq_pkg::buf_wr_t             wr,
	output logic [1:0]                   full,
	output jdq_pkg::buf_rd_t             rd,
	input  logic [jdq_pkg::SAMPLE_W-1:0] rdata,
	output logic                         res_valid,
	input  logic                         res_stall,
	output jdq_pkg::out_item_t           res_data
);

	logic [1:0]                full_q;
	logic                      drain_bank_q;
	logic [jdq_pkg::IDX_W-1:0] rd_idx_q;
	logic                      pend_q;
	logic [jdq_pkg::IDX_W-1:0] pend_idx_q;
	logic                      out_valid_q;
	jdq_pkg::out_item_t        out_q;
	logic                      move;
	logic                      issue;

	assign move  = pend_q && (!out_valid_q || !res_stall);
	assign issue = full_q[drain_bank_q] && (!pend_q || move);

	assign full      = full_q;
	assign rd.re     = issue;
	assign rd.addr   = {drain_bank_q, rd_idx_q};
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q       <= '0;
			drain_bank_q <= 1'b0;
			rd_idx_q     <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (wr.done && (wr.addr[jdq_pkg::BANK_BIT] == b[0])) begin
					full_q[b] <= 1'b1;
				end else if (issue && (rd_idx_q == jdq_pkg::LAST_IDX) &&
						(drain_bank_q == b[0])) begin
					full_q[b] <= 1'b0;
				end
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_idx_q == jdq_pkg::LAST_IDX) begin
					drain_bank_q <= !drain_bank_q;
				end
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pend_idx_q <= rd_idx_q;
		end
		if (move) begin
			out_q.sample        <= rdata;
			out_q.natural_index <= pend_idx_q;
			out_q.last          <= (pend_idx_q == jdq_pkg::LAST_IDX);
		end
	end

endmodule

FILE: design/jpeg_dequant_unzigzag_unit.sv
`timescale 1ns / 1ps
// JPEG inverse quantization and inverse zigzag, ping-pong block buffer.
// Throughput: one item per cycle in, one per cycle out while draining; both can stall.
// A block's last write sets its bank full flag; reads pass the RAM and output register.
// Input stalls only when both buffer banks hold blocks not yet fully read out.
// Reset clears counters, bank flags and valids; table and buffer RAMs are not reset.
module jpeg_dequant_unzigzag_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  jdq_pkg::in_item_t  src_data,
	output logic               res_valid,
	input  logic               res_stall,
	output jdq_pkg::out_item_t res_data
);

	jdq_pkg::buf_wr_t             wr;
	jdq_pkg::buf_rd_t             rd;
	logic [1:0]                   full;
	logic [jdq_pkg::SAMPLE_W-1:0] buf_rdata;

	jdq_fill u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.full      (full),
		.wr        (wr)
	);

	jdq_ram #(
		.WIDTH (jdq_pkg::SAMPLE_W),
		.DEPTH (jdq_pkg::BUF_DEPTH)
	) u_buf_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (buf_rdata)
	);

	jdq_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.full      (full),
		.rd        (rd),
		.rdata     (buf_rdata),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

FILE: design/jdq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the dequantizer output channel, bound to the top level.
// Depends on jdq_pkg and jpeg_dequant_unzigzag_unit.
module jdq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input jdq_pkg::out_item_t res_data
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("stalled result changed");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.last == (res_data.natural_index == jdq_pkg::LAST_IDX)))
		else $error("last flag not on final raster position");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_data.last |=> res_valid)
		else $error("gap inside a block readout");

endmodule

bind jpeg_dequant_unzigzag_unit jdq_checker u_jdq_checker (.*);
